@@ src/ordered_callback_table_macros.svh @@
// ----------------------------------------------------------------------------
// ordered callback table assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ORDERED_CALLBACK_TABLE_MACROS_SVH
`define ORDERED_CALLBACK_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define OCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered_callback_table: same-cycle check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define OCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered_callback_table: next-cycle check failed");

`endif

@@ src/occ_pkg.sv @@
// ----------------------------------------------------------------------------
// occ_pkg
// types and codes shared by the ordered callback table modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package occ_pkg;

  localparam int IdW    = 16;
  localparam int OwnerW = 32;
  localparam int PayW   = 32;
  localparam int PosW   = 6;
  localparam int TallyW = 7;

  // request kinds
  localparam logic [2:0] KIND_APPEND = 3'd0;
  localparam logic [2:0] KIND_FIND   = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_ROWNER = 3'd3;
  localparam logic [2:0] KIND_COUNT  = 3'd4;
  localparam logic [2:0] KIND_NTH    = 3'd5;
  localparam logic [2:0] KIND_AT     = 3'd6;
  localparam logic [2:0] KIND_CLEAR  = 3'd7;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [OwnerW-1:0] owner;
    logic [PayW-1:0]   payload;
  } occ_entry_t;

  typedef struct packed {
    logic id_eq;
    logic owner_eq;
  } occ_cmp_t;

endpackage

@@ src/ordered_callback_table.sv @@
// ----------------------------------------------------------------------------
// ordered_callback_table
// insertion-ordered table of (event id, owner, payload) entries
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Every transaction
// gives exactly one result, shown on the result ports for one cycle while
// done_o is high; the receiver cannot hold it off.
// Append and clear, and an at-position request beyond the entries in use,
// finish at once: done_o is high in the cycle after the transaction.
// Find, remove, remove owner, count, nth-of-id scan the entries in use one
// slot per cycle through the single read port of the entry store and one
// shared compare unit; remove and remove owner write the kept entries back,
// packed toward slot zero, in the same pass. An at-position request within
// the entries in use reads that one slot the same way.
// busy stays high until the result shows;
// a new transaction may be taken in the cycle the result is shown.
// Reset empties the table at once (fill count to zero); the store itself is
// not cleared, since no slot beyond the fill count is ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_callback_table import occ_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        kind_i,
  input  logic [IdW-1:0]    event_id_i,
  input  logic [OwnerW-1:0] owner_handle_i,
  input  logic [PayW-1:0]   payload_i,
  input  logic              entry_valid_i,
  input  logic [PosW-1:0]   position_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [IdW-1:0]    hit_id_o,
  output logic [OwnerW-1:0] hit_owner_o,
  output logic [PayW-1:0]   hit_payload_o,
  output logic [TallyW-1:0] tally_o
);

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > TallyW) ? CntW : TallyW;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_q, state_d;
  logic [2:0]        kind_q;
  logic [IdW-1:0]    key_id_q;
  logic [OwnerW-1:0] key_owner_q;
  logic [PosW-1:0]   pos_q;
  logic [CntW-1:0]   fill_q;
  logic [CntW-1:0]   rd_q;
  logic [CntW-1:0]   end_q;
  logic [CntW-1:0]   wr_q;
  logic [CntW-1:0]   nth_q;
  logic              vld_q;
  logic              found_q;
  logic [TallyW-1:0] tally_q;
  logic [1:0]        status_q;
  logic              done_q;
  occ_entry_t        hit_q;

  logic       accept;
  logic       issue;
  logic       scan_end;
  logic       take, drop, cnt, nth_inc, compact;
  logic       pos_in_use;
  logic       full;
  occ_entry_t rdata;
  occ_entry_t wdata;
  logic       we;
  logic [IdxW-1:0] waddr;
  occ_cmp_t   cmp;

  assign accept     = start && !busy;
  assign busy       = (state_q != S_IDLE);
  assign full       = (fill_q >= CapCnt);
  assign pos_in_use = (CmpW'(position_i) < CmpW'(fill_q));
  assign issue      = (state_q == S_SCAN) && (rd_q < end_q);
  assign scan_end   = (state_q == S_SCAN) && !issue && !vld_q;
  assign compact    = (kind_q == KIND_REMOVE) || (kind_q == KIND_ROWNER);

  occ_mem #(
    .Depth (CAPACITY),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  occ_match u_match (
    .entry_i     (rdata),
    .key_id_i    (key_id_q),
    .key_owner_i (key_owner_q),
    .cmp_o       (cmp)
  );

  // what the entry coming out of the store means for the current request
  always_comb begin
    take    = 1'b0;
    drop    = 1'b0;
    cnt     = 1'b0;
    nth_inc = 1'b0;
    case (kind_q)
      KIND_FIND: begin
        take = cmp.id_eq && cmp.owner_eq && !found_q;
      end
      KIND_REMOVE: begin
        take = cmp.id_eq && cmp.owner_eq && !found_q;
        drop = take;
      end
      KIND_ROWNER: begin
        drop = cmp.owner_eq;
        cnt  = cmp.owner_eq;
      end
      KIND_COUNT: begin
        cnt = cmp.id_eq;
      end
      KIND_NTH: begin
        take    = cmp.id_eq && !found_q && (CmpW'(nth_q) == CmpW'(pos_q));
        nth_inc = cmp.id_eq;
      end
      KIND_AT: begin
        take = !found_q;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  // write port: append while idle, compaction write-back while scanning
  always_comb begin
    if (state_q == S_IDLE) begin
      we    = accept && (kind_i == KIND_APPEND) && entry_valid_i && !full;
      waddr = fill_q[IdxW-1:0];
      wdata = '{id: event_id_i, owner: owner_handle_i, payload: payload_i};
    end else begin
      we    = vld_q && compact && !drop;
      waddr = wr_q[IdxW-1:0];
      wdata = rdata;
    end
  end

  always_comb begin
    state_d = state_q;
    if (state_q == S_IDLE) begin
      if (accept && (kind_i != KIND_APPEND) && (kind_i != KIND_CLEAR) &&
          ((kind_i != KIND_AT) || pos_in_use)) begin
        state_d = S_SCAN;
      end
    end else if (scan_end) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      rd_q     <= '0;
      end_q    <= '0;
      wr_q     <= '0;
      nth_q    <= '0;
      vld_q    <= 1'b0;
      found_q  <= 1'b0;
      tally_q  <= '0;
      status_q <= ST_OK;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (state_q == S_IDLE) begin
        vld_q <= 1'b0;
        if (accept) begin
          found_q  <= 1'b0;
          tally_q  <= '0;
          nth_q    <= '0;
          wr_q     <= '0;
          status_q <= ST_OK;
          if (kind_i == KIND_AT) begin
            rd_q  <= CntW'(position_i);
            end_q <= CntW'(position_i) + CntW'(1);
          end else begin
            rd_q  <= '0;
            end_q <= fill_q;
          end
          case (kind_i)
            KIND_APPEND: begin
              done_q <= 1'b1;
              if (!entry_valid_i) begin
                status_q <= ST_INVALID;
              end else if (full) begin
                status_q <= ST_FULL;
              end else begin
                fill_q <= fill_q + CntW'(1);
              end
            end
            KIND_CLEAR: begin
              done_q <= 1'b1;
              fill_q <= '0;
            end
            KIND_AT: begin
              if (!pos_in_use) begin
                done_q   <= 1'b1;
                status_q <= ST_NOT_FOUND;
              end
            end
            default: begin
              done_q <= 1'b0;
            end
          endcase
        end
      end else begin
        rd_q  <= rd_q + CntW'(issue);
        vld_q <= issue;
        if (vld_q) begin
          wr_q    <= wr_q + CntW'(compact && !drop);
          tally_q <= tally_q + TallyW'(cnt);
          nth_q   <= nth_q + CntW'(nth_inc);
          if (take) begin
            found_q <= 1'b1;
          end
        end
        if (scan_end) begin
          done_q <= 1'b1;
          if (compact) begin
            fill_q <= wr_q;
          end
          if (kind_q == KIND_REMOVE) begin
            tally_q <= TallyW'(found_q);
          end
          if ((kind_q == KIND_FIND) || (kind_q == KIND_REMOVE) ||
              (kind_q == KIND_NTH) || (kind_q == KIND_AT)) begin
            status_q <= found_q ? ST_OK : ST_NOT_FOUND;
          end else begin
            status_q <= ST_OK;
          end
        end
      end
    end
  end

  // request key and captured entry
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_i;
      key_id_q    <= event_id_i;
      key_owner_q <= owner_handle_i;
      pos_q       <= position_i;
      hit_q       <= '0;
    end else if ((state_q == S_SCAN) && vld_q && take) begin
      hit_q <= rdata;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign hit_id_o      = hit_q.id;
  assign hit_owner_o   = hit_q.owner;
  assign hit_payload_o = hit_q.payload;
  assign tally_o       = tally_q;

endmodule

@@ src/occ_mem.sv @@
// ----------------------------------------------------------------------------
// occ_mem
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module occ_mem import occ_pkg::*; #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  occ_entry_t       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output occ_entry_t       rdata_o
);

  occ_entry_t mem_q [Depth];
  occ_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/occ_match.sv @@
// ----------------------------------------------------------------------------
// occ_match
// compare unit: checks one stored entry against the request key
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module occ_match import occ_pkg::*; (
  input  occ_entry_t        entry_i,
  input  logic [IdW-1:0]    key_id_i,
  input  logic [OwnerW-1:0] key_owner_i,
  output occ_cmp_t          cmp_o
);

  always_comb begin
    cmp_o.id_eq    = (entry_i.id == key_id_i);
    cmp_o.owner_eq = (entry_i.owner == key_owner_i);
  end

endmodule

@@ src/occ_chk.sv @@
// ----------------------------------------------------------------------------
// occ_chk
// port-level checks for the ordered callback table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ordered_callback_table_macros.svh"

module occ_chk import occ_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [2:0]        kind_i,
  input logic              done_o,
  input logic [1:0]        status_o,
  input logic [IdW-1:0]    hit_id_o,
  input logic [OwnerW-1:0] hit_owner_o,
  input logic [PayW-1:0]   hit_payload_o,
  input logic [TallyW-1:0] tally_o
);

  // a result always lands with the block idle again
  `OCC_ASSERT_IMP(a_done_idle, done_o, !busy)

  // a scan starting never coincides with a result
  `OCC_ASSERT_IMP(a_scan_no_done, $rose(busy), !done_o)

  // a failing answer carries no entry and no tally
  `OCC_ASSERT_IMP(a_fail_empty, done_o && (status_o != ST_OK),
    (hit_id_o == '0) && (hit_owner_o == '0) && (hit_payload_o == '0) && (tally_o == '0))

  // clear answers at once with a clean ok
  `OCC_ASSERT_NXT(a_clear_now, start && !busy && (kind_i == KIND_CLEAR),
    done_o && (status_o == ST_OK) && (tally_o == '0) && !busy)

endmodule

bind ordered_callback_table occ_chk u_occ_chk (.*);
